/* design/brf_pkg.sv */
// Shared types and operation codes for the byte ring FIFO.
package brf_pkg;

   localparam logic [2:0] OP_WRITE     = 3'd0;
   localparam logic [2:0] OP_OVERWRITE = 3'd1;
   localparam logic [2:0] OP_READ      = 3'd2;
   localparam logic [2:0] OP_SKIP      = 3'd3;
   localparam logic [2:0] OP_ERASE     = 3'd4;

   localparam int          FILL_W       = 11;
   localparam int          COUNT_W      = 16;
   localparam int          SIZE_W       = 4;
   localparam logic [3:0]  SIZE_RESET   = 4'd10;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_in;
      logic       last_of_call;
   } brf_req_type;

   typedef struct packed {
      logic [7:0]         data_out;
      logic               done_res;
      logic [COUNT_W-1:0] call_done_count;
      logic [FILL_W-1:0]  fill_level;
      logic               is_empty;
      logic               is_full;
   } brf_rsp_type;

   typedef struct packed {
      logic load;
      logic cfg_write;
   } brf_cmd_type;

endpackage

/* design/brf_ctrl.sv */
// Controller: accepts one word at a time and presents its result the next cycle.
module brf_ctrl
   import brf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        csr_valid,
   output logic        busy,
   output logic        csr_ready,
   output logic        rsp_valid,
   output brf_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type state_ff;

   assign busy          = (state_ff == ST_RESP);
   assign rsp_valid     = (state_ff == ST_RESP);
   assign csr_ready     = (state_ff == ST_IDLE) && !start;
   assign cmd.load      = start && (state_ff == ST_IDLE);
   assign cmd.cfg_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* design/brf_datapath.sv */
// Datapath: byte ring memory, free-running pointers, call counter and result registers.
module brf_datapath
   import brf_pkg::*;
#(
   parameter int DEPTH = 1024
)
(
   input  logic              clock,
   input  logic              reset,
   input  brf_cmd_type       cmd,
   input  brf_req_type       req_data,
   input  logic [SIZE_W-1:0] csr_data,
   output brf_rsp_type       rsp_data
);

   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PTR_W    = AW + 1;
   localparam int MAX_LOG2 = $clog2(DEPTH + 1) - 1;

   logic [7:0]         mem [DEPTH];

   logic [SIZE_W-1:0]  size_ff;
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [PTR_W-1:0]   rp_ff, rp_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]         rd_ff;
   logic               rd_done_ff, rd_done_in;
   brf_rsp_type        res_ff, res_in;

   logic [SIZE_W-1:0]  eff_log2;
   logic [PTR_W-1:0]   cap;
   logic [PTR_W-1:0]   cap_m1;
   logic [PTR_W-1:0]   fill_now;
   logic [PTR_W-1:0]   fill_new;
   logic [PTR_W+FILL_W-1:0] fill_ext;
   logic [AW-1:0]      waddr;
   logic [AW-1:0]      raddr;
   logic               full;
   logic               empty;
   logic               done;
   logic               we;

   always_comb begin
      if (int'(size_ff) > MAX_LOG2) begin
         eff_log2 = SIZE_W'(MAX_LOG2);
      end else begin
         eff_log2 = size_ff;
      end
   end

   assign cap      = PTR_W'(1) << eff_log2;
   assign cap_m1   = cap - PTR_W'(1);
   assign fill_now = wp_ff - rp_ff;
   assign full     = (fill_now == cap);
   assign empty    = (fill_now == '0);
   assign waddr    = wp_ff[AW-1:0] & cap_m1[AW-1:0];
   assign raddr    = rp_ff[AW-1:0] & cap_m1[AW-1:0];

   always_comb begin
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      done       = 1'b0;
      we         = 1'b0;
      rd_done_in = 1'b0;
      unique case (req_data.operation)
         OP_WRITE: begin
            if (!full) begin
               we    = 1'b1;
               wp_in = wp_ff + PTR_W'(1);
               done  = 1'b1;
            end
         end
         OP_OVERWRITE: begin
            if (full) begin
               rp_in = rp_ff + PTR_W'(1);
            end
            we    = 1'b1;
            wp_in = wp_ff + PTR_W'(1);
            done  = 1'b1;
         end
         OP_READ: begin
            if (!empty) begin
               rp_in      = rp_ff + PTR_W'(1);
               rd_done_in = 1'b1;
               done       = 1'b1;
            end
         end
         OP_SKIP: begin
            if (!empty) begin
               rp_in = rp_ff + PTR_W'(1);
               done  = 1'b1;
            end
         end
         OP_ERASE: begin
            if (!empty) begin
               wp_in = wp_ff - PTR_W'(1);
               done  = 1'b1;
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   assign fill_new = wp_in - rp_in;
   assign fill_ext = {{FILL_W{1'b0}}, fill_new};

   always_comb begin
      cnt_in = cnt_ff;
      if (done && (cnt_ff != {COUNT_W{1'b1}})) begin
         cnt_in = cnt_ff + COUNT_W'(1);
      end
      res_in                 = '0;
      res_in.done_res        = done;
      res_in.fill_level      = fill_ext[FILL_W-1:0];
      res_in.is_empty        = (fill_new == '0);
      res_in.is_full         = (fill_new == cap);
      if (req_data.last_of_call) begin
         res_in.call_done_count = cnt_in;
         cnt_in                 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
      end else if (cmd.cfg_write) begin
         size_ff <= csr_data;
         wp_ff   <= '0;
         rp_ff   <= '0;
      end else if (cmd.load) begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (we) begin
            mem[waddr] <= req_data.data_in;
         end
         rd_ff      <= mem[raddr];
         rd_done_ff <= rd_done_in;
         res_ff     <= res_in;
      end
   end

   always_comb begin
      rsp_data          = res_ff;
      rsp_data.data_out = rd_done_ff ? rd_ff : 8'd0;
   end

endmodule

/* design/byte_ring_fifo_top.sv */
// Byte ring FIFO top level: controller plus ring datapath.
// Latency: the result of a word accepted at one edge shows on rsp ports the next cycle.
// The controller takes no new word while a result shows; busy is high during the result cycle.
// Reset: pointers and call count clear, size_log2 returns to 10; ring contents stay undefined.
// The receiver cannot stall: each result shows for exactly one cycle with rsp_valid.
module byte_ring_fifo_top
   import brf_pkg::*;
#(
   parameter int DEPTH = 1024
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  brf_req_type       req_data,
   output logic              rsp_valid,
   output brf_rsp_type       rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_data
);

   brf_cmd_type cmd;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .busy      (busy),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   brf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

endmodule
